// File: design/mmt_pkg.sv
// Shared types and constants for the Mobius / Mertens lookup block.
`timescale 1ns / 1ps
package mmt_pkg;

	localparam int QUERY_W = 16;
	localparam int MOB_W   = 2;
	localparam int MERT_W  = 13;
	localparam int RUN_W   = 18;

	localparam logic signed [RUN_W-1:0] MERT_MAX = 18'sd4095;
	localparam logic signed [RUN_W-1:0] MERT_MIN = -18'sd4096;

	// one table word: Mertens sum, composite flag, Mobius value
	typedef struct packed {
		logic signed [MERT_W-1:0] mert;
		logic                     comp;
		logic signed [MOB_W-1:0]  mob;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_WALK_RD,
		ST_WALK_WR,
		ST_MERT_RD,
		ST_MERT_WR,
		ST_READY
	} phase_t;

endpackage

// File: design/mobius_mertens_table_top.sv
// Top level of the Mobius / Mertens lookup block: table build sequencer and query path.
`timescale 1ns / 1ps
// After reset the block builds one table of words {M(n), composite, mu(n)} for n up to
// min(MAX_N, 65535) in a single RAM, and holds s_tready low until the build is done.
// The build is a sequence of single-entry passes over that RAM: an init sweep, a prime
// scan, a read-modify-write walk over the multiples of each prime (multiples of p*p are
// zeroed in the same walk), and a running-sum pass for M(n). After that each query is a
// single read of the RAM, answered through the registered RAM read and the output
// register, with one query accepted every cycle while the result side keeps up. A query
// of 0 or above MAX_N gives no result. M(n) saturates at -4096 and 4095.
module mobius_mertens_table_top #(
	parameter int MAX_N = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] query_n
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [15:0] echo_n, [17:16] mobius_value,
	                               // [30:18] mertens_value, [31] zero
);

	import mmt_pkg::*;

	localparam int TOP   = (MAX_N < 65535) ? MAX_N : 65535;
	localparam int DEPTH = TOP + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int KW    = $clog2(2 * TOP + 1);

	localparam logic [QUERY_W-1:0] TOP_Q = QUERY_W'(TOP);
	localparam logic [KW-1:0]      TOP_K = KW'(TOP);
	localparam logic [AW-1:0]      TOP_A = AW'(TOP);

	phase_t state_q, state_d;

	logic [KW-1:0]           k_q;
	logic [AW-1:0]           p_q;
	logic [AW-1:0]           c_q;
	logic signed [RUN_W-1:0] run_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	entry_t        ram_rdata;

	logic [KW-1:0]           k_next;
	logic                    walk_done;
	logic                    c_wrap;
	logic signed [RUN_W-1:0] run_sum;
	logic signed [MERT_W-1:0] mert_sat;

	logic                  accept;
	logic                  in_range;
	logic                  out_free;
	logic                  q_valid_s1;
	logic [QUERY_W-1:0]    q_n_s1;
	logic                  out_valid_q;
	logic [QUERY_W-1:0]    out_n_q;
	logic signed [MOB_W-1:0]  out_mob_q;
	logic signed [MERT_W-1:0] out_mert_q;

	mmt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign k_next    = k_q + KW'(p_q);
	assign walk_done = k_next > TOP_K;
	assign c_wrap    = c_q == p_q;
	assign run_sum   = run_q + RUN_W'(ram_rdata.mob);

	always_comb begin
		if (run_sum > MERT_MAX) begin
			mert_sat = MERT_W'(MERT_MAX);
		end else if (run_sum < MERT_MIN) begin
			mert_sat = MERT_W'(MERT_MIN);
		end else begin
			mert_sat = MERT_W'(run_sum);
		end
	end

	// query handshake
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_READY) && (!q_valid_s1 || out_free);
	assign accept   = s_tvalid && s_tready;
	assign in_range = (s_tdata != '0) && (s_tdata <= TOP_Q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (k_q == TOP_K) state_d = ST_SCAN_RD;
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (!ram_rdata.comp) begin
					state_d = ST_WALK_RD;
				end else if (p_q == TOP_A) begin
					state_d = ST_MERT_RD;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_WALK_RD: begin
				state_d = ST_WALK_WR;
			end
			ST_WALK_WR: begin
				if (!walk_done) begin
					state_d = ST_WALK_RD;
				end else if (p_q == TOP_A) begin
					state_d = ST_MERT_RD;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_MERT_RD: begin
				state_d = ST_MERT_WR;
			end
			ST_MERT_WR: begin
				state_d = (k_q == TOP_K) ? ST_READY : ST_MERT_RD;
			end
			ST_READY: begin
				state_d = ST_READY;
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = k_q[AW-1:0];
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = k_q[AW-1:0];
		unique case (state_q)
			ST_INIT: begin
				ram_we         = 1'b1;
				ram_wdata.mert = '0;
				ram_wdata.comp = k_q < KW'(2);
				ram_wdata.mob  = (k_q == '0) ? MOB_W'(0) : MOB_W'(1);
			end
			ST_SCAN_RD: begin
				ram_re    = 1'b1;
				ram_raddr = p_q;
			end
			ST_WALK_RD, ST_MERT_RD: begin
				ram_re = 1'b1;
			end
			ST_WALK_WR: begin
				// flip the sign; zero on every multiple of p*p; mark all but p itself
				ram_we         = 1'b1;
				ram_wdata.mob  = c_wrap ? MOB_W'(0) : MOB_W'(-ram_rdata.mob);
				ram_wdata.comp = ram_rdata.comp || (k_q[AW-1:0] != p_q);
			end
			ST_MERT_WR: begin
				ram_we         = 1'b1;
				ram_wdata.mert = mert_sat;
			end
			ST_READY: begin
				ram_re    = accept;
				ram_raddr = s_tdata[AW-1:0];
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// build counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			k_q     <= '0;
			p_q     <= AW'(2);
			c_q     <= AW'(1);
			run_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_INIT: begin
					k_q <= k_q + KW'(1);
				end
				ST_SCAN_CHK: begin
					if (!ram_rdata.comp) begin
						k_q <= KW'(p_q);
						c_q <= AW'(1);
					end else if (p_q == TOP_A) begin
						k_q   <= KW'(1);
						run_q <= '0;
					end else begin
						p_q <= p_q + AW'(1);
					end
				end
				ST_WALK_WR: begin
					c_q <= c_wrap ? AW'(1) : c_q + AW'(1);
					if (walk_done && p_q == TOP_A) begin
						k_q   <= KW'(1);
						run_q <= '0;
					end else begin
						k_q <= k_next;
						if (walk_done) begin
							p_q <= p_q + AW'(1);
						end
					end
				end
				ST_MERT_WR: begin
					run_q <= run_sum;
					k_q   <= k_q + KW'(1);
				end
				default: begin
					run_q <= run_q;
				end
			endcase
		end
	end

	// query pipeline: RAM read stage, then output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_valid_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				q_valid_s1 <= in_range;
			end else if (out_free) begin
				q_valid_s1 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= q_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_n_s1 <= s_tdata;
		end
		if (out_free && q_valid_s1) begin
			out_n_q    <= q_n_s1;
			out_mob_q  <= ram_rdata.mob;
			out_mert_q <= ram_rdata.mert;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_mert_q, out_mob_q, out_n_q};

endmodule

// File: design/mmt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module mmt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
